[src/kpi_pkg.sv]
package kpi_pkg;

  localparam int MaxWaypoints = 32;
  localparam int IdxW = $clog2(MaxWaypoints);
  localparam int CntW = $clog2(MaxWaypoints + 1);

  localparam logic [1:0] StQuery  = 2'd0;
  localparam logic [1:0] StStored = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;
  localparam logic [1:0] StEmpty  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RD_A,
    S_RD_B,
    S_COMP,
    S_DIV,
    S_DONE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

[src/kpi_divider.sv]
// Restoring divider, one quotient bit per cycle: q = n / d (41-bit n, 24-bit d)
module kpi_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [40:0]          num,
  input  logic [23:0]          den,
  output kpi_pkg::div_ctl_t    ctl,
  output logic [40:0]          quo
);
  logic [40:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [25:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = '0;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 6'd41;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[40]} - {2'b0, den};
      if (!trial[25]) begin
        rem_nxt = trial[24:0];
        q_nxt = {q_r[39:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[23:0], q_r[40]};
        q_nxt = {q_r[39:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign quo = q_r;
endmodule

[src/keyframe_path_interpolator_core.sv]
// Keyframe path interpolator; one word in flight, next accepted the cycle after the result is taken.
// Load word or empty-table query: result offered the cycle after accept. Query word: each entry
// scanned is read and checked, the segment is fetched, then six components each pass a compute and a
// divide state (41-step divide, skipped when no divide is needed), then a finish state to out_valid.
// rst_n (synchronous, active low) empties the table and idles the sequencer;
// table contents are not cleared.
module keyframe_path_interpolator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [23:0]        in_time_req,
  input  logic signed [15:0] in_in_pos_x,
  input  logic signed [15:0] in_in_pos_y,
  input  logic signed [15:0] in_in_pos_z,
  input  logic signed [15:0] in_in_dir_x,
  input  logic signed [15:0] in_in_dir_y,
  input  logic signed [15:0] in_in_dir_z,
  input  logic               in_look_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_out_pos_x,
  output logic signed [15:0] out_out_pos_y,
  output logic signed [15:0] out_out_pos_z,
  output logic signed [16:0] out_out_dir_x,
  output logic signed [16:0] out_out_dir_y,
  output logic signed [16:0] out_out_dir_z,
  output logic               out_finished,
  output logic [1:0]         out_status
);
  localparam int IW = kpi_pkg::IdxW;
  localparam int CW = kpi_pkg::CntW;

  // waypoint memory: time, pos xyz, dir xyz, mode = 121 bits
  logic [120:0] mem [kpi_pkg::MaxWaypoints];
  logic [120:0] rd_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;

  kpi_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] scan_r;
  logic [23:0]   t_r;
  logic [IW-1:0] idx_r;
  logic          at_end_r;
  logic [120:0]  a_r, b_r;    // waypoint idx and idx+1 (or segment pair)
  logic [2:0]    comp_r;      // component 0..5
  logic          last_r;      // idx == last
  logic [23:0]   num_r, den_r;
  logic signed [16:0] res_r [6];
  logic          dneg_r;
  logic [1:0]    status_r;
  logic          fin_r;
  logic          div_start;
  logic [40:0]   quo;
  kpi_pkg::div_ctl_t dctl;

  logic [23:0] prev_time_r;

  assign in_ready  = (st_r == kpi_pkg::S_IDLE);
  assign out_valid = (st_r == kpi_pkg::S_OUT);
  wire accept = in_valid && in_ready;
  assign wr_en = accept && !in_req_type && (cnt_r < CW'(kpi_pkg::MaxWaypoints));

  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r[IW-1:0]] <= {in_time_req, in_in_pos_x, in_in_pos_y, in_in_pos_z,
                                       in_in_dir_x, in_in_dir_y, in_in_dir_z, in_look_mode};
    rd_r <= mem[rd_addr];
  end

  // field helpers on a stored word
  function automatic logic signed [15:0] fld(input logic [120:0] w, input logic [2:0] c);
    logic signed [15:0] v;
    case (c)
      3'd0: v = w[96:81];
      3'd1: v = w[80:65];
      3'd2: v = w[64:49];
      3'd3: v = w[48:33];
      3'd4: v = w[32:17];
      3'd5: v = w[16:1];
      default: v = '0;
    endcase
    return v;
  endfunction

  // waypoint idx is in motion mode (mode bit clear): direction is a segment delta
  logic motion;
  assign motion = !a_r[0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      kpi_pkg::S_IDLE:     if (accept) st_nxt = in_req_type && cnt_r != '0 ?
                                         kpi_pkg::S_SCAN_RD : kpi_pkg::S_OUT;
      kpi_pkg::S_SCAN_RD:  st_nxt = kpi_pkg::S_SCAN_CHK;
      kpi_pkg::S_SCAN_CHK: begin
        if (rd_r[120:97] > t_r || scan_r == cnt_r - CW'(1)) st_nxt = kpi_pkg::S_RD_A;
        else st_nxt = kpi_pkg::S_SCAN_RD;
      end
      kpi_pkg::S_RD_A:     st_nxt = kpi_pkg::S_RD_B;
      kpi_pkg::S_RD_B:     st_nxt = kpi_pkg::S_COMP;
      kpi_pkg::S_COMP:     st_nxt = kpi_pkg::S_DIV;
      kpi_pkg::S_DIV:      if (!dctl.busy && !dctl.start)
                             st_nxt = (comp_r == 3'd5) ? kpi_pkg::S_DONE : kpi_pkg::S_COMP;
      kpi_pkg::S_DONE:     st_nxt = kpi_pkg::S_OUT;
      kpi_pkg::S_OUT:      if (out_ready) st_nxt = kpi_pkg::S_IDLE;
      default:             st_nxt = kpi_pkg::S_IDLE;
    endcase
  end

  // read address: scan entry, then idx (A) and idx+1 / pair for B
  logic [IW-1:0] last_idx, seg_s;
  assign last_idx = IW'(cnt_r - CW'(1));
  always_comb begin
    rd_addr = scan_r[IW-1:0];
    seg_s = last_r ? last_idx - IW'(1) : idx_r;
    case (st_r)
      kpi_pkg::S_SCAN_RD: rd_addr = scan_r[IW-1:0];
      kpi_pkg::S_RD_A:    rd_addr = idx_r;
      kpi_pkg::S_RD_B:    rd_addr = last_r ? seg_s : idx_r + IW'(1);
      default:            rd_addr = scan_r[IW-1:0];
    endcase
  end

  // per-component operands: on the first component b is still in rd_r
  logic [120:0]       bw_c;
  logic signed [16:0] av_c, bv_c, d_c;
  always_comb begin
    bw_c = (comp_r == 3'd0) ? rd_r : b_r;
    av_c = 17'(fld(a_r, comp_r));
    bv_c = 17'(fld(bw_c, comp_r));
    d_c = bv_c - av_c;
  end

  assign div_start = (st_r == kpi_pkg::S_COMP) && !last_r && (num_r != '0);

  logic [16:0] mag;
  assign mag = d_c[16] ? 17'(-d_c) : 17'(d_c);
  logic [40:0] prod;
  assign prod = 41'(mag) * 41'(num_r) + 41'(den_r >> 1);

  kpi_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(prod), .den(den_r), .ctl(dctl), .quo(quo)
  );

  logic signed [16:0] q_s;
  assign q_s = dneg_r ? -$signed(quo[16:0]) : $signed(quo[16:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kpi_pkg::S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (wr_en) cnt_r <= cnt_r + CW'(1);
    end
    case (st_r)
      kpi_pkg::S_IDLE: if (accept) begin
        t_r <= in_time_req;
        scan_r <= '0;
        idx_r <= last_idx;
        at_end_r <= 1'b1;
        num_r <= '0;
        den_r <= '0;
        fin_r <= 1'b0;
        comp_r <= '0;
        for (int k = 0; k < 6; k++) res_r[k] <= '0;
        if (!in_req_type) status_r <= wr_en ? kpi_pkg::StStored : kpi_pkg::StFull;
        else status_r <= (cnt_r == '0) ? kpi_pkg::StEmpty : kpi_pkg::StQuery;
      end
      kpi_pkg::S_SCAN_CHK: begin
        prev_time_r <= rd_r[120:97];
        if (rd_r[120:97] > t_r) begin
          at_end_r <= 1'b0;
          if (scan_r != '0) begin
            idx_r <= IW'(scan_r - CW'(1));
            num_r <= t_r - prev_time_r;
            den_r <= rd_r[120:97] - prev_time_r;
          end else idx_r <= '0;
        end
        scan_r <= scan_r + CW'(1);
      end
      kpi_pkg::S_RD_A: last_r <= (idx_r == last_idx);
      kpi_pkg::S_RD_B: begin
        a_r <= rd_r;
        if (last_r) num_r <= '0;
      end
      kpi_pkg::S_COMP: begin
        fin_r <= at_end_r;
      end
      default: ;
    endcase
    // per-component evaluation: S_COMP on first entry has b in rd_r
    if (st_r == kpi_pkg::S_COMP) begin
      dneg_r <= d_c[16];
      if (comp_r == 3'd0) b_r <= rd_r;
    end
    if (st_r == kpi_pkg::S_DIV && !dctl.busy && !dctl.start) begin
      if (comp_r < 3'd3 || !motion)
        res_r[comp_r] <= (last_r || num_r == '0) ? av_c : av_c + q_s;
      comp_r <= comp_r + 3'd1;
    end
    if (st_r == kpi_pkg::S_DONE && motion) begin
      for (int k = 0; k < 3; k++) begin
        if (cnt_r == CW'(1)) res_r[3+k] <= '0;
        else if (last_r)
          res_r[3+k] <= 17'(fld(b_r, 3'(k))) - 17'(fld(a_r, 3'(k)));
        else
          res_r[3+k] <= 17'(fld(b_r, 3'(k))) - 17'(fld(a_r, 3'(k)));
      end
    end
  end

  // in the last-entry case a_r = entry last, b_r = entry last-1: fix sign
  logic signed [16:0] dir_o [3];
  always_comb begin
    for (int k = 0; k < 3; k++)
      dir_o[k] = (motion && last_r && cnt_r != CW'(1)) ? -res_r[3+k] : res_r[3+k];
  end

  assign out_out_pos_x = res_r[0][15:0];
  assign out_out_pos_y = res_r[1][15:0];
  assign out_out_pos_z = res_r[2][15:0];
  assign out_out_dir_x = dir_o[0];
  assign out_out_dir_y = dir_o[1];
  assign out_out_dir_z = dir_o[2];
  assign out_finished  = fin_r;
  assign out_status    = status_r;
endmodule

[tb/tb_keyframe_path_interpolator_core.sv]
`timescale 1ns / 1ps

module tb_keyframe_path_interpolator_core;

  // request codes on in_req_type
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic MODE_MOTION = 1'b0;
  localparam logic MODE_LOOK   = 1'b1;

  localparam int IDLE_LIMIT  = 20000;  // cycles without a handshake on either side
  localparam int LONG_HOLD   = 2000;   // receiver hold-off for back-pressure
  localparam int DRAIN_WAIT  = 800;    // longer than the slowest query
  localparam int RAND_ITEMS  = 600;

  typedef struct {
    logic               req;
    logic [23:0]        tm;
    logic signed [15:0] px, py, pz;
    logic signed [15:0] dx, dy, dz;
    logic               mode;
  } path_word_t;

  typedef struct {
    logic signed [15:0] px, py, pz;
    logic signed [16:0] dx, dy, dz;
    logic               fin;
    logic [1:0]         st;
  } path_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_req_type;
  logic [23:0]        in_time_req;
  logic signed [15:0] in_in_pos_x, in_in_pos_y, in_in_pos_z;
  logic signed [15:0] in_in_dir_x, in_in_dir_y, in_in_dir_z;
  logic               in_look_mode;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_out_pos_x, out_out_pos_y, out_out_pos_z;
  logic signed [16:0] out_out_dir_x, out_out_dir_y, out_out_dir_z;
  logic               out_finished;
  logic [1:0]         out_status;

  keyframe_path_interpolator_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_time_req  (in_time_req),
    .in_in_pos_x  (in_in_pos_x),
    .in_in_pos_y  (in_in_pos_y),
    .in_in_pos_z  (in_in_pos_z),
    .in_in_dir_x  (in_in_dir_x),
    .in_in_dir_y  (in_in_dir_y),
    .in_in_dir_z  (in_in_dir_z),
    .in_look_mode (in_look_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_pos_x(out_out_pos_x),
    .out_out_pos_y(out_out_pos_y),
    .out_out_pos_z(out_out_pos_z),
    .out_out_dir_x(out_out_dir_x),
    .out_out_dir_y(out_out_dir_y),
    .out_out_dir_z(out_out_dir_z),
    .out_finished (out_finished),
    .out_status   (out_status)
  );

  // 2 ns clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  path_word_t   pending_words[$];
  path_result_t expected_results[$];

  // shadow copy of the waypoint table
  logic [23:0] wp_time [kpi_pkg::MaxWaypoints];
  int          wp_pos  [kpi_pkg::MaxWaypoints][3];
  int          wp_dir  [kpi_pkg::MaxWaypoints][3];
  logic        wp_mode [kpi_pkg::MaxWaypoints];
  int          wp_count;

  int n_loads, n_refused, n_queries, n_empty, n_finished, n_results, n_errors;
  bit in_fire;
  bit long_hold_done;
  int idle_cycles;

  // round(delta*num/den), ties away from zero
  function automatic int seg_scale(int delta, longint unsigned num, longint unsigned den);
    longint unsigned mag, q;
    if (den == 0) return 0;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    q = (mag * num + den / 2) / den;
    return (delta < 0) ? -int'(q) : int'(q);
  endfunction

  // Applies one word to the shadow table and returns its result.
  function automatic path_result_t predict_path(path_word_t w);
    path_result_t r;
    int pos[3], dir[3];
    int last, idx, s, k;
    longint unsigned num, den;
    bit at_end, found;
    pos = '{0, 0, 0};
    dir = '{0, 0, 0};
    r.fin = 1'b0;
    if (w.req == REQ_LOAD) begin
      if (wp_count < kpi_pkg::MaxWaypoints) begin
        wp_time[wp_count] = w.tm;
        wp_pos[wp_count] = '{int'(w.px), int'(w.py), int'(w.pz)};
        wp_dir[wp_count] = '{int'(w.dx), int'(w.dy), int'(w.dz)};
        wp_mode[wp_count] = w.mode;
        wp_count++;
        r.st = kpi_pkg::StStored;
      end else begin
        r.st = kpi_pkg::StFull;
      end
    end else if (wp_count == 0) begin
      r.st = kpi_pkg::StEmpty;
    end else begin
      last = wp_count - 1;
      idx = last;
      num = 0;
      den = 0;
      at_end = 1'b1;
      found = 1'b0;
      for (int i = 0; i < wp_count && !found; i++) begin
        if (wp_time[i] > w.tm) begin
          found = 1'b1;
          at_end = 1'b0;
          if (i == 0) begin
            idx = 0;  // before the first waypoint: clamp, fraction zero
          end else begin
            idx = i - 1;
            num = w.tm - wp_time[idx];
            den = wp_time[i] - wp_time[idx];
          end
        end
      end
      if (idx == last) num = 0;
      for (k = 0; k < 3; k++) begin
        pos[k] = (idx == last) ? wp_pos[idx][k] :
          wp_pos[idx][k] + seg_scale(wp_pos[idx+1][k] - wp_pos[idx][k], num, den);
      end
      if (wp_mode[idx] == MODE_MOTION) begin
        // motion: segment delta, previous segment at the end, zero if alone
        if (last >= 1) begin
          s = (idx == last) ? last - 1 : idx;
          for (k = 0; k < 3; k++) dir[k] = wp_pos[s+1][k] - wp_pos[s][k];
        end
      end else begin
        for (k = 0; k < 3; k++) begin
          dir[k] = (idx == last) ? wp_dir[idx][k] :
            wp_dir[idx][k] + seg_scale(wp_dir[idx+1][k] - wp_dir[idx][k], num, den);
        end
      end
      r.fin = at_end;
      r.st = kpi_pkg::StQuery;
    end
    r.px = pos[0][15:0];
    r.py = pos[1][15:0];
    r.pz = pos[2][15:0];
    r.dx = dir[0][16:0];
    r.dy = dir[1][16:0];
    r.dz = dir[2][16:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_load(logic [23:0] tm, logic mode);
    path_word_t w;
    w.req = REQ_LOAD;
    w.tm = tm;
    w.px = rand_q88(); w.py = rand_q88(); w.pz = rand_q88();
    w.dx = rand_q88(); w.dy = rand_q88(); w.dz = rand_q88();
    w.mode = mode;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_query(logic [23:0] tm);
    path_word_t w;
    w.req = REQ_QUERY;
    w.tm = tm;
    // payload is ignored on queries; keep it random anyway
    w.px = 16'($urandom); w.py = 16'($urandom); w.pz = 16'($urandom);
    w.dx = 16'($urandom); w.dy = 16'($urandom); w.dz = 16'($urandom);
    w.mode = 1'($urandom);
    pending_words.insert(pending_words.size(), w);
  endtask

  // Driver: bursts with random gaps, updates at the falling edge.
  int burst_left, gap_left;
  always @(negedge clk) begin
    path_word_t w;
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // hold the offered word
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_valid     <= 1'b1;
        in_req_type  <= w.req;
        in_time_req  <= w.tm;
        in_in_pos_x  <= w.px;
        in_in_pos_y  <= w.py;
        in_in_pos_z  <= w.pz;
        in_in_dir_x  <= w.dx;
        in_in_dir_y  <= w.dy;
        in_in_dir_z  <= w.dz;
        in_look_mode <= w.mode;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternates free-running and choppy stretches, plus one long
  // hold-off so the input side backs up against the single word in flight.
  int rx_phase, rx_hold;
  bit rx_choppy;
  always @(negedge clk) begin
    if (rst_n) begin
      rx_phase <= rx_phase + 1;
      if (rx_phase % 97 == 0) rx_choppy <= $urandom_range(0, 1);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (!long_hold_done && n_results == 150) begin
        out_ready <= 1'b0;
        rx_hold <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (rx_choppy) begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor and scoreboard at the rising edge.
  always @(posedge clk) begin
    path_word_t w;
    path_result_t e;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        w.req = in_req_type;  w.tm = in_time_req;
        w.px = in_in_pos_x;   w.py = in_in_pos_y;  w.pz = in_in_pos_z;
        w.dx = in_in_dir_x;   w.dy = in_in_dir_y;  w.dz = in_in_dir_z;
        w.mode = in_look_mode;
        e = predict_path(w);
        expected_results.insert(expected_results.size(), e);
        if (w.req == REQ_LOAD) begin
          if (e.st == kpi_pkg::StFull) n_refused++; else n_loads++;
        end else begin
          n_queries++;
          if (e.st == kpi_pkg::StEmpty) n_empty++;
          if (e.fin) n_finished++;
        end
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          n_errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_out_pos_x !== e.px) begin
            $error("pos_x exp %0d got %0d", e.px, out_out_pos_x); n_errors++;
          end
          if (out_out_pos_y !== e.py) begin
            $error("pos_y exp %0d got %0d", e.py, out_out_pos_y); n_errors++;
          end
          if (out_out_pos_z !== e.pz) begin
            $error("pos_z exp %0d got %0d", e.pz, out_out_pos_z); n_errors++;
          end
          if (out_out_dir_x !== e.dx) begin
            $error("dir_x exp %0d got %0d", e.dx, out_out_dir_x); n_errors++;
          end
          if (out_out_dir_y !== e.dy) begin
            $error("dir_y exp %0d got %0d", e.dy, out_out_dir_y); n_errors++;
          end
          if (out_out_dir_z !== e.dz) begin
            $error("dir_z exp %0d got %0d", e.dz, out_out_dir_z); n_errors++;
          end
          if (out_finished !== e.fin) begin
            $error("finished exp %0d got %0d", e.fin, out_finished); n_errors++;
          end
          if (out_status !== e.st) begin
            $error("status exp %0d got %0d", e.st, out_status); n_errors++;
          end
        end
      end
    end
  end

  // Watchdog on stalled handshakes.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("keyframe_path_interpolator_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [23:0] last_t, t;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_time_req = '0;
    in_in_pos_x = '0; in_in_pos_y = '0; in_in_pos_z = '0;
    in_in_dir_x = '0; in_in_dir_y = '0; in_in_dir_z = '0;
    in_look_mode = MODE_MOTION;
    out_ready = 1'b0;
    wp_count = 0;
    burst_left = 0; gap_left = 0;
    rx_phase = 0; rx_hold = 0; rx_choppy = 0;

    // directed: empty table, single waypoint, clamp, end, unsorted, look
    push_query(24'd0);
    push_query(24'hffffff);
    push_load(24'd100, MODE_MOTION);
    push_query(24'd0);         // before first waypoint
    push_query(24'd100);
    push_query(24'hffffff);    // single waypoint, motion dir zero
    push_load(24'hffffff, MODE_LOOK);
    push_query(24'd99);
    push_query(24'd8000000);
    push_query(24'hfffffe);
    push_query(24'hffffff);    // at last waypoint, look mode keeps its stored direction
    push_load(24'd5000, MODE_LOOK);  // unsorted time
    push_query(24'd4999);
    push_query(24'd5000);
    push_query(24'd16000000);
    push_load(24'd5000, MODE_MOTION);
    push_query(24'd5000);
    push_query(24'hffffff);
    last_t = 24'd5000;

    // random: grow the table with queries interleaved, then mostly queries
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ((n < 400 && $urandom_range(0, 9) < 3) || $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          t = 24'($urandom);
        end else begin
          t = (last_t > 24'hffffff - 24'd600000) ? 24'($urandom) :
              last_t + 24'($urandom_range(0, 500000));
          last_t = t;
        end
        push_load(t, 1'($urandom));
      end else begin
        pick = $urandom_range(0, 3);
        if (pick == 0) t = 24'($urandom);
        else if (pick == 1) t = last_t + 24'($urandom_range(0, 4)) - 24'd2;
        else t = 24'($urandom_range(0, int'(last_t) + 1000));
        push_query(t);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() > 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      n_errors++;
    end

    $display("covered %0d loads, %0d refused loads, %0d queries (%0d on empty table,",
             n_loads, n_refused, n_queries, n_empty);
    $display("%0d past the end), %0d results checked, %0d mismatches",
             n_finished, n_results, n_errors);
    if (n_errors == 0) begin
      $display("keyframe_path_interpolator_core regression: pass");
    end else begin
      $display("keyframe_path_interpolator_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/kpi_pkg.sv
src/kpi_divider.sv
src/keyframe_path_interpolator_core.sv
tb/tb_keyframe_path_interpolator_core.sv
